// File: rtl/trio_transmission_sorter_core_defines.svh
// Assertion macros used by the checker file of the trio transmission sorter.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef TRIO_TRANSMISSION_SORTER_CORE_DEFINES_SVH
`define TRIO_TRANSMISSION_SORTER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define TTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tts assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define TTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tts assertion failed");

// Next-cycle implication that also holds across reset.
`define TTS_ASSERT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tts assertion failed");

`endif

// File: rtl/tts_pkg.sv
// Types, allele codes and helpers for the trio transmission sorter.
// No dependencies; used by tts_sort and trio_transmission_sorter_core.
package tts_pkg;

    localparam logic [1:0] ALLELE_UNKNOWN = 2'd0;
    localparam logic [1:0] ALLELE_1       = 2'd1;
    localparam logic [1:0] ALLELE_2       = 2'd2;

    typedef logic [1:0] t_allele;

    typedef struct packed {
        t_allele child_first;
        t_allele child_second;
        t_allele father_first;
        t_allele father_second;
        t_allele mother_first;
        t_allele mother_second;
    } t_geno;

    typedef struct packed {
        t_allele case_from_father;
        t_allele case_from_mother;
        t_allele control_from_father;
        t_allele control_from_mother;
        logic    de_novo_flag;
        logic    father_nonmendelian;
        logic    mother_nonmendelian;
        logic    sort_error;
    } t_result;

    // Swap allele 1 and allele 2 (t % 2 + 1).
    function automatic t_allele other_allele(input t_allele a);
        return {1'b0, a[0]} + 2'd1;
    endfunction

    function automatic logic is_known(input t_allele a);
        return (a == ALLELE_1) || (a == ALLELE_2);
    endfunction

endpackage

// File: rtl/trio_transmission_sorter_core.sv
// A locus passes through the input register and then the result register to result valid.
// Throughput: one locus per cycle unless i_ready stalls the result; the sorting logic sits between the two registers.
// Both stages advance together whenever the result register is empty or being taken.
// Reset (i_rst_n low, synchronous) empties both stages; payload registers are not cleared.
// Top level of the trio transmission sorter; depends on tts_pkg and tts_sort.
module trio_transmission_sorter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_child_first,
    input  logic [1:0] i_child_second,
    input  logic [1:0] i_father_first,
    input  logic [1:0] i_father_second,
    input  logic [1:0] i_mother_first,
    input  logic [1:0] i_mother_second,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_case_from_father,
    output logic [1:0] o_case_from_mother,
    output logic [1:0] o_control_from_father,
    output logic [1:0] o_control_from_mother,
    output logic       o_de_novo_flag,
    output logic       o_father_nonmendelian,
    output logic       o_mother_nonmendelian,
    output logic       o_sort_error
);

    logic             r_s1_valid, n_s1_valid;
    tts_pkg::t_geno   r_s1_geno,  n_s1_geno;
    logic             r_s2_valid, n_s2_valid;
    tts_pkg::t_result r_s2_res,   n_s2_res;
    tts_pkg::t_result sort_res;
    logic             s2_free;

    tts_sort u_sort (
        .i_geno (r_s1_geno),
        .o_res  (sort_res)
    );

    // result stage can load when empty or its beat is taken now
    assign s2_free = !r_s2_valid || i_ready;
    assign o_ready = !r_s1_valid || s2_free;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_geno  = r_s1_geno;
        n_s2_valid = r_s2_valid;
        n_s2_res   = r_s2_res;
        if (s2_free) begin
            n_s2_valid = r_s1_valid;
            n_s2_res   = sort_res;
        end
        if (o_ready) begin
            n_s1_valid = i_valid;
            n_s1_geno  = '{child_first:   i_child_first,
                           child_second:  i_child_second,
                           father_first:  i_father_first,
                           father_second: i_father_second,
                           mother_first:  i_mother_first,
                           mother_second: i_mother_second};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_geno <= n_s1_geno;
        r_s2_res  <= n_s2_res;
    end

    assign o_valid               = r_s2_valid;
    assign o_case_from_father    = r_s2_res.case_from_father;
    assign o_case_from_mother    = r_s2_res.case_from_mother;
    assign o_control_from_father = r_s2_res.control_from_father;
    assign o_control_from_mother = r_s2_res.control_from_mother;
    assign o_de_novo_flag        = r_s2_res.de_novo_flag;
    assign o_father_nonmendelian = r_s2_res.father_nonmendelian;
    assign o_mother_nonmendelian = r_s2_res.mother_nonmendelian;
    assign o_sort_error          = r_s2_res.sort_error;

endmodule

// File: rtl/tts_sort.sv
// Combinational case/control sorting of one trio genotype.
// Depends on tts_pkg for the genotype and result structs.
module tts_sort (
    input  tts_pkg::t_geno   i_geno,
    output tts_pkg::t_result o_res
);

    tts_pkg::t_allele c   [2];
    tts_pkg::t_allele par [2][2];

    assign c[0]      = i_geno.child_first;
    assign c[1]      = i_geno.child_second;
    assign par[0][0] = i_geno.father_first;
    assign par[0][1] = i_geno.father_second;
    assign par[1][0] = i_geno.mother_first;
    assign par[1][1] = i_geno.mother_second;

    always_comb begin
        tts_pkg::t_allele ca [2];
        tts_pkg::t_allele co [2];
        logic [1:0] nm;
        logic [1:0] asg;
        logic [1:0] has;
        logic       dn;
        logic       err;
        logic       fin;
        logic       known;
        logic       found;
        logic       claimed;
        logic       taken;
        logic [1:0] n;
        logic [1:0] k;
        tts_pkg::t_allele t;
        logic [3:0] sum_c;
        logic [3:0] sum_ca;
        logic [3:0] sum_par;
        logic [3:0] sum_all;

        ca[0] = '0; ca[1] = '0; co[0] = '0; co[1] = '0;
        nm = '0; asg = '0; has = '0;
        dn = 1'b0; err = 1'b0; fin = 1'b0;
        found = 1'b0; claimed = 1'b0; taken = 1'b0;
        n = '0; k = '0; t = '0;

        known = tts_pkg::is_known(c[0]) && tts_pkg::is_known(c[1])
             && tts_pkg::is_known(par[0][0]) && tts_pkg::is_known(par[0][1])
             && tts_pkg::is_known(par[1][0]) && tts_pkg::is_known(par[1][1]);

        // both parents 11
        if (par[0][0] == tts_pkg::ALLELE_1 && par[0][1] == tts_pkg::ALLELE_1
            && par[1][0] == tts_pkg::ALLELE_1 && par[1][1] == tts_pkg::ALLELE_1) begin
            if (c[0] == tts_pkg::ALLELE_1 && c[1] == tts_pkg::ALLELE_1) begin
                ca[0] = tts_pkg::ALLELE_1; ca[1] = tts_pkg::ALLELE_1;
                co[0] = tts_pkg::ALLELE_1; co[1] = tts_pkg::ALLELE_1;
                fin = 1'b1;
            end else begin
                co[0] = tts_pkg::ALLELE_1; co[1] = tts_pkg::ALLELE_1;
                ca[0] = c[0]; ca[1] = c[1];
                dn = 1'b1;
            end
        end

        // homozygous child: each parent gives the child allele if it can
        if (!fin && c[0] == c[1]) begin
            t = c[0];
            for (int p = 0; p < 2; p++) begin
                found = 1'b0;
                for (int a = 0; a < 2; a++) begin
                    if (!found && par[1'(p)][1'(a)] == t) begin
                        ca[1'(p)] = t;
                        co[1'(p)] = par[1'(p)][1'(1 - a)];
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    nm[1'(p)] = 1'b1;
                    ca[1'(p)] = t;
                    co[1'(p)] = par[1'(p)][0];
                end
                asg[1'(p)] = 1'b1;
            end
            fin = 1'b1;
        end

        if (!fin) begin
            // each child allele: homozygous parent claims first, then a unique owner
            for (int d = 0; d < 2; d++) begin
                t = c[1'(d)];
                n = '0;
                has = '0;
                claimed = 1'b0;
                for (int p = 0; p < 2; p++) begin
                    if (!claimed && !asg[1'(p)]) begin
                        k = '0;
                        for (int a = 0; a < 2; a++) begin
                            if (par[1'(p)][1'(a)] == t) begin
                                n = n + 2'd1;
                                k = k + 2'd1;
                                has[1'(p)] = 1'b1;
                            end
                        end
                        if (k == 2'd2) begin
                            ca[1'(p)] = t;
                            co[1'(p)] = t;
                            asg[1'(p)] = 1'b1;
                            claimed = 1'b1;
                        end
                    end
                end
                if (!claimed) begin
                    if (n == 2'd1) begin
                        taken = 1'b0;
                        for (int p = 0; p < 2; p++) begin
                            if (!taken && has[1'(p)]) begin
                                ca[1'(p)] = t;
                                co[1'(p)] = (par[1'(p)][0] == t) ? par[1'(p)][1]
                                                                 : par[1'(p)][0];
                                asg[1'(p)] = 1'b1;
                                taken = 1'b1;
                            end
                        end
                    end else if (n == 2'd0) begin
                        nm[1'(d)] = 1'b1;
                    end
                end
            end

            // fallback for parents left unassigned
            if (!asg[0] || !asg[1]) begin
                if (nm[0] && nm[1]) begin
                    co[0] = par[0][0];
                    co[1] = par[0][0];
                    ca[0] = tts_pkg::other_allele(par[0][0]);
                    ca[1] = tts_pkg::other_allele(par[0][0]);
                end else if (nm[0] || nm[1]) begin
                    for (int p = 0; p < 2; p++) begin
                        if (!asg[1'(p)]) begin
                            ca[1'(p)] = tts_pkg::other_allele(par[1'(p)][0]);
                            co[1'(p)] = par[1'(p)][0];
                        end
                    end
                end else if (!asg[0] && !asg[1]) begin
                    ca[0] = par[0][0];
                    co[1] = par[0][0];
                    ca[1] = tts_pkg::other_allele(par[0][0]);
                    co[0] = tts_pkg::other_allele(par[0][0]);
                end else if (!asg[0]) begin
                    if (par[0][0] != par[0][1]) begin
                        err = 1'b1;
                    end else begin
                        ca[0] = par[0][0];
                        co[0] = par[0][0];
                    end
                end else begin
                    err = 1'b1;
                end
            end
        end

        // sum checks
        sum_c   = 4'(c[0]) + 4'(c[1]);
        sum_ca  = 4'(ca[0]) + 4'(ca[1]);
        sum_par = 4'(par[0][0]) + 4'(par[0][1]) + 4'(par[1][0]) + 4'(par[1][1]);
        sum_all = sum_ca + 4'(co[0]) + 4'(co[1]);
        if (sum_c != sum_ca) begin
            err = 1'b1;
        end
        if (sum_par != sum_all && !nm[0] && !nm[1] && !dn) begin
            err = 1'b1;
        end

        if (known) begin
            o_res.case_from_father    = ca[0];
            o_res.case_from_mother    = ca[1];
            o_res.control_from_father = co[0];
            o_res.control_from_mother = co[1];
            o_res.de_novo_flag        = dn;
            o_res.father_nonmendelian = !dn && nm[0];
            o_res.mother_nonmendelian = !dn && nm[1];
            o_res.sort_error          = err;
        end else begin
            o_res = '0;
        end
    end

endmodule

// File: rtl/tts_checker.sv
// Port-level checks for trio_transmission_sorter_core, attached by bind.
// Depends on trio_transmission_sorter_core_defines.svh for the assertion macros.
`include "trio_transmission_sorter_core_defines.svh"

module tts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_case_from_father,
    input logic [1:0] o_case_from_mother,
    input logic [1:0] o_control_from_father,
    input logic [1:0] o_control_from_mother,
    input logic       o_de_novo_flag,
    input logic       o_father_nonmendelian,
    input logic       o_mother_nonmendelian,
    input logic       o_sort_error
);

    logic [11:0] res_bits;

    assign res_bits = {o_case_from_father, o_case_from_mother, o_control_from_father,
                       o_control_from_mother, o_de_novo_flag, o_father_nonmendelian,
                       o_mother_nonmendelian, o_sort_error};

    // hold a stalled result beat
    `TTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(res_bits))

    // de novo masks the per-parent flags
    `TTS_ASSERT_IMP(a_dn_mask, i_clk, i_rst_n, o_valid && o_de_novo_flag, !o_father_nonmendelian && !o_mother_nonmendelian)

    // de novo only arises with both parents 11, so both controls are allele 1
    `TTS_ASSERT_IMP(a_dn_ctrl, i_clk, i_rst_n, o_valid && o_de_novo_flag, o_control_from_father == 2'd1 && o_control_from_mother == 2'd1)

    // reset empties the pipeline
    `TTS_ASSERT_ALL(a_rst_empty, i_clk, !i_rst_n, !o_valid)

endmodule

bind trio_transmission_sorter_core tts_checker u_tts_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_valid               (o_valid),
    .i_ready               (i_ready),
    .o_case_from_father    (o_case_from_father),
    .o_case_from_mother    (o_case_from_mother),
    .o_control_from_father (o_control_from_father),
    .o_control_from_mother (o_control_from_mother),
    .o_de_novo_flag        (o_de_novo_flag),
    .o_father_nonmendelian (o_father_nonmendelian),
    .o_mother_nonmendelian (o_mother_nonmendelian),
    .o_sort_error          (o_sort_error)
);
